// ===== src/vcrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video register copy engine package
// Shared item types, command codes, register indexes and register tables.
// ----------------------------------------------------------------------------
package vcrc_pkg;

  localparam int VRAM_ADDR_BITS = 16;
  localparam int VRAM_DEPTH     = 1 << VRAM_ADDR_BITS;
  localparam int NUM_REGS       = 38;

  typedef logic [VRAM_ADDR_BITS-1:0] vram_addr_t;

  typedef enum logic [2:0] {
    CMD_SELECT = 3'd0,
    CMD_STATUS = 3'd1,
    CMD_REG_RD = 3'd2,
    CMD_REG_WR = 3'd3,
    CMD_TICK   = 3'd4,
    CMD_PEN    = 3'd5
  } cmd_e;

  localparam logic [5:0] REG_PEN_HI    = 6'h10;
  localparam logic [5:0] REG_PEN_LO    = 6'h11;
  localparam logic [5:0] REG_UPD_HI    = 6'h12;
  localparam logic [5:0] REG_UPD_LO    = 6'h13;
  localparam logic [5:0] REG_COPY_MODE = 6'h18;
  localparam logic [5:0] REG_WORDS     = 6'h1e;
  localparam logic [5:0] REG_DATA      = 6'h1f;
  localparam logic [5:0] REG_BLK_HI    = 6'h20;
  localparam logic [5:0] REG_BLK_LO    = 6'h21;
  localparam logic [5:0] REG_POLARITY  = 6'h25;

  localparam logic [7:0] POLARITY_RESET = 8'hc0;
  localparam logic [7:0] UNMAPPED_READ  = 8'hff;

  localparam logic [7:0] WRITE_MASK [NUM_REGS] = '{
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h1f, 8'hff, 8'hff,
    8'h03, 8'h1f, 8'h7f, 8'h1f, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h1f,
    8'hff, 8'hff, 8'hff, 8'hff, 8'he0, 8'h1f, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'h0f, 8'hc0
  };

  localparam logic [7:0] READ_ONES [NUM_REGS] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hc0, 8'h00, 8'h00,
    8'hfc, 8'he0, 8'h80, 8'he0, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'he0,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h1f, 8'he0, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'hf0, 8'h3f
  };

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  bus_data;
    logic        in_vblank;
    logic [15:0] pen_position;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       copy_ready;
  } out_item_t;

  typedef struct packed {
    logic       rd_en;
    vram_addr_t rd_addr;
    logic       wr_en;
    vram_addr_t wr_addr;
    logic [7:0] wr_data;
  } vram_req_t;

endpackage

// ===== src/video_controller_register_copy_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video controller register copy engine
// Bus side of a text-mode video controller with block fill and copy.
// ----------------------------------------------------------------------------
// Each item is held in the item register, waits on the registered video RAM
// read for a data-port read or copy tick, then its result is registered out.
// One item is taken per cycle unless a read phase or an output stall holds it.
// Synchronous reset restores control registers, not data registers or RAM.
module video_controller_register_copy_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vcrc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vcrc_pkg::out_item_t out_data
);
  import vcrc_pkg::*;

  in_item_t  item_r;
  logic      item_v_r;
  logic      phase_r;
  out_item_t out_r;
  logic      out_v_r;
  logic      needs_read;
  logic      done;
  logic      accept;
  vram_req_t ram_req;
  logic [7:0] ram_rdata;
  out_item_t result;

  assign done     = item_v_r && (!needs_read || phase_r) && (!out_v_r || out_ready);
  assign in_ready = !item_v_r || done;
  assign accept   = in_valid && in_ready;

  vcrc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_v_r),
    .phase      (phase_r),
    .commit     (done),
    .item       (item_r),
    .ram_rdata  (ram_rdata),
    .needs_read (needs_read),
    .ram_req    (ram_req),
    .result     (result)
  );

  vcrc_vram u_vram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (done) begin
      out_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      phase_r  <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (accept) begin
        item_v_r <= 1'b1;
      end else if (done) begin
        item_v_r <= 1'b0;
      end
      if (accept || done) begin
        phase_r <= 1'b0;
      end else if (item_v_r && needs_read) begin
        phase_r <= 1'b1;
      end
      if (done) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_phase_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> item_v_r)
    else $error("read phase without a held item");

  a_ram_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.rd_en && ram_req.wr_en))
    else $error("video RAM read and write in the same cycle");

  a_commit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid)
    else $error("completed item did not reach the output register");

  a_held_item_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (item_v_r && !done) |-> !in_ready)
    else $error("input taken while an item is still in work");

endmodule

// ===== src/vcrc_vram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video RAM
// Single write port and single registered read port byte memory.
// ----------------------------------------------------------------------------
module vcrc_vram (
  input  logic               clk,
  input  vcrc_pkg::vram_req_t req,
  output logic [7:0]         rd_data
);
  import vcrc_pkg::*;

  logic [7:0] mem [VRAM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== src/vcrc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register file and copy engine
// Decodes one command, holds the controller state and drives video RAM.
// ----------------------------------------------------------------------------
module vcrc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  logic                phase,
  input  logic                commit,
  input  vcrc_pkg::in_item_t  item,
  input  logic [7:0]          ram_rdata,
  output logic                needs_read,
  output vcrc_pkg::vram_req_t ram_req,
  output vcrc_pkg::out_item_t result
);
  import vcrc_pkg::*;

  logic [5:0]  sel_r, sel_nxt;
  logic [7:0]  reg_file_r [NUM_REGS];
  logic [7:0]  rf_q_r, rf_q_nxt;
  logic [15:0] upd_r, upd_nxt;
  logic [15:0] blk_r, blk_nxt;
  logic [7:0]  words_r, words_nxt;
  logic [7:0]  fill_r, fill_nxt;
  logic        ready_r, ready_nxt;
  logic        latched_r, latched_nxt;
  logic [15:0] pen_r, pen_nxt;
  logic        reg_wr;
  logic [7:0]  reg_wdata;
  logic        ram_wr;
  logic [7:0]  ram_wdata;
  logic [7:0]  rd;
  logic        copy_mode;
  logic        mapped;

  assign copy_mode = reg_file_r[REG_COPY_MODE][7];
  assign mapped    = (sel_r < 6'(NUM_REGS));
  assign reg_wdata = item.bus_data & WRITE_MASK[sel_r];

  // The register file is read through a registered port that follows the
  // select latch, so it always holds the entry at the current select.
  assign rf_q_nxt = reg_wr ? reg_wdata :
                    (sel_nxt < 6'(NUM_REGS)) ? reg_file_r[sel_nxt] : 8'h00;

  assign needs_read = (item.cmd == CMD_REG_RD && sel_r == REG_DATA) ||
                      (item.cmd == CMD_TICK && !ready_r && copy_mode);

  always_comb begin
    sel_nxt     = sel_r;
    upd_nxt     = upd_r;
    blk_nxt     = blk_r;
    words_nxt   = words_r;
    fill_nxt    = fill_r;
    ready_nxt   = ready_r;
    latched_nxt = latched_r;
    pen_nxt     = pen_r;
    reg_wr      = 1'b0;
    ram_wr      = 1'b0;
    ram_wdata   = fill_r;
    rd          = 8'h00;
    case (item.cmd)
      CMD_SELECT: sel_nxt = item.bus_data[5:0];
      CMD_STATUS: rd = {ready_r, latched_r, item.in_vblank, 4'b0000, 1'b1};
      CMD_REG_RD: begin
        if (!mapped) begin
          rd = UNMAPPED_READ;
        end else begin
          unique case (sel_r)
            REG_PEN_HI: begin
              rd          = pen_r[15:8];
              latched_nxt = 1'b0;
            end
            REG_PEN_LO: begin
              rd          = pen_r[7:0];
              latched_nxt = 1'b0;
            end
            REG_UPD_HI: rd = upd_r[15:8];
            REG_UPD_LO: rd = upd_r[7:0];
            REG_WORDS:  rd = words_r;
            REG_DATA: begin
              rd      = ram_rdata;
              upd_nxt = upd_r + 16'd1;
            end
            REG_BLK_HI: rd = blk_r[15:8];
            REG_BLK_LO: rd = blk_r[7:0];
            default:    rd = rf_q_r | READ_ONES[sel_r];
          endcase
        end
      end
      CMD_REG_WR: begin
        if (mapped) begin
          unique case (sel_r)
            REG_PEN_HI, REG_PEN_LO: ;
            REG_UPD_HI: upd_nxt = {item.bus_data, upd_r[7:0]};
            REG_UPD_LO: upd_nxt = {upd_r[15:8], item.bus_data};
            REG_WORDS: begin
              words_nxt = item.bus_data;
              ready_nxt = 1'b0;
            end
            REG_DATA: begin
              fill_nxt  = item.bus_data;
              ram_wr    = 1'b1;
              ram_wdata = item.bus_data;
              upd_nxt   = upd_r + 16'd1;
            end
            REG_BLK_HI: blk_nxt = {item.bus_data, blk_r[7:0]};
            REG_BLK_LO: blk_nxt = {blk_r[15:8], item.bus_data};
            default:    reg_wr = 1'b1;
          endcase
        end
      end
      CMD_TICK: begin
        if (!ready_r) begin
          if (copy_mode) begin
            ram_wdata = ram_rdata;
            blk_nxt   = blk_r + 16'd1;
          end
          ram_wr    = 1'b1;
          upd_nxt   = upd_r + 16'd1;
          words_nxt = words_r - 8'd1;
          ready_nxt = (words_nxt == 8'd0);
        end
      end
      CMD_PEN: begin
        pen_nxt     = item.pen_position;
        latched_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  assign ram_req.rd_en   = item_valid && !phase && needs_read;
  assign ram_req.rd_addr = (item.cmd == CMD_TICK) ? blk_r[VRAM_ADDR_BITS-1:0]
                                                  : upd_r[VRAM_ADDR_BITS-1:0];
  assign ram_req.wr_en   = commit && ram_wr;
  assign ram_req.wr_addr = upd_r[VRAM_ADDR_BITS-1:0];
  assign ram_req.wr_data = ram_wdata;

  assign result.read_data  = rd;
  assign result.copy_ready = ready_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r     <= '0;
      rf_q_r    <= 8'h00;
      upd_r     <= '0;
      blk_r     <= '0;
      words_r   <= '0;
      fill_r    <= '0;
      ready_r   <= 1'b1;
      latched_r <= 1'b0;
      pen_r     <= '0;
      for (int i = 0; i < NUM_REGS; i++) begin
        reg_file_r[i] <= (6'(i) == REG_POLARITY) ? POLARITY_RESET : 8'h00;
      end
    end else if (commit) begin
      sel_r     <= sel_nxt;
      rf_q_r    <= rf_q_nxt;
      upd_r     <= upd_nxt;
      blk_r     <= blk_nxt;
      words_r   <= words_nxt;
      fill_r    <= fill_nxt;
      ready_r   <= ready_nxt;
      latched_r <= latched_nxt;
      pen_r     <= pen_nxt;
      if (reg_wr) begin
        reg_file_r[sel_r] <= reg_wdata;
      end
    end
  end

endmodule

// ===== verif/tb_video_controller_register_copy_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the video controller register copy engine
// Runs register, status, light pen, data port and block fill/copy traffic
// through the bus port under random stalls on both sides. Every result is
// checked against a cycle-free behavioral copy of the controller.
// ----------------------------------------------------------------------------
module tb_video_controller_register_copy_engine;
  import vcrc_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 6;
  localparam int ITEM_TARGET  = 1875;
  localparam int QUIET_TAIL   = 150;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 60;
  localparam int PAUSE_AT     = 1000;
  localparam int LIMIT_CYCLES = 400000;

  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;
  localparam logic [5:0] REG_LAST     = 6'h3f;

  typedef struct packed {
    logic      pause;
    out_item_t reply;
    in_item_t  req;
  } request_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic [7:0] write_keep [NUM_REGS] = '{
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h1f, 8'hff, 8'hff,
    8'h03, 8'h1f, 8'h7f, 8'h1f, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h1f,
    8'hff, 8'hff, 8'hff, 8'hff, 8'he0, 8'h1f, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'h0f, 8'hc0
  };

  logic [7:0] fixed_ones [NUM_REGS] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hc0, 8'h00, 8'h00,
    8'hfc, 8'he0, 8'h80, 8'he0, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'he0,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h1f, 8'he0, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'hf0, 8'h3f
  };

  logic [5:0]  ctl_select;
  logic [7:0]  ctl_regs [NUM_REGS];
  logic [15:0] ctl_update_ptr;
  logic [15:0] ctl_block_ptr;
  logic [7:0]  ctl_words_left;
  logic [7:0]  ctl_fill;
  logic        ctl_ready;
  logic        ctl_pen_latched;
  logic [15:0] ctl_pen_addr;
  logic [7:0]  ctl_vram [65536];
  bit          ctl_vram_written [65536];

  request_t  queued_requests [$];
  out_item_t pending_replies [$];
  out_item_t cur_reply;

  bit in_hs;
  bit quiet_tail;
  bit pause_next;
  bit hold_done;
  int send_gap;
  int recv_gap;
  int hold_left;
  int total_requests;
  int n_queued;
  int n_accepted;
  int n_results;
  int n_mismatch;
  int n_bytes_moved;
  int n_vram_reads;
  int n_cycles;

  video_controller_register_copy_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic int vram_index(logic [15:0] addr);
    return int'(addr) & ((1 << VRAM_ADDR_BITS) - 1);
  endfunction

  function out_item_t controller_response(in_item_t req);
    out_item_t  reply;
    logic [7:0] rd;
    logic [7:0] moved;
    rd = 8'h00;
    case (req.cmd)
      CMD_SELECT: begin
        ctl_select = req.bus_data[5:0];
      end
      CMD_STATUS: begin
        rd = {ctl_ready, ctl_pen_latched, req.in_vblank, 4'b0000, 1'b1};
      end
      CMD_REG_RD: begin
        if (ctl_select >= NUM_REGS) begin
          rd = UNMAPPED_READ;
        end else begin
          case (ctl_select)
            REG_PEN_HI: begin
              rd = ctl_pen_addr[15:8];
              ctl_pen_latched = 1'b0;
            end
            REG_PEN_LO: begin
              rd = ctl_pen_addr[7:0];
              ctl_pen_latched = 1'b0;
            end
            REG_UPD_HI: rd = ctl_update_ptr[15:8];
            REG_UPD_LO: rd = ctl_update_ptr[7:0];
            REG_WORDS:  rd = ctl_words_left;
            REG_DATA: begin
              rd = ctl_vram[vram_index(ctl_update_ptr)];
              ctl_update_ptr++;
              n_vram_reads++;
            end
            REG_BLK_HI: rd = ctl_block_ptr[15:8];
            REG_BLK_LO: rd = ctl_block_ptr[7:0];
            default:    rd = ctl_regs[ctl_select] | fixed_ones[ctl_select];
          endcase
        end
      end
      CMD_REG_WR: begin
        if (ctl_select < NUM_REGS) begin
          case (ctl_select)
            REG_PEN_HI, REG_PEN_LO: ;
            REG_UPD_HI: ctl_update_ptr[15:8] = req.bus_data;
            REG_UPD_LO: ctl_update_ptr[7:0] = req.bus_data;
            REG_WORDS: begin
              ctl_words_left = req.bus_data;
              ctl_ready = 1'b0;
            end
            REG_DATA: begin
              ctl_fill = req.bus_data;
              ctl_vram[vram_index(ctl_update_ptr)] = req.bus_data;
              ctl_vram_written[vram_index(ctl_update_ptr)] = 1'b1;
              ctl_update_ptr++;
            end
            REG_BLK_HI: ctl_block_ptr[15:8] = req.bus_data;
            REG_BLK_LO: ctl_block_ptr[7:0] = req.bus_data;
            default:    ctl_regs[ctl_select] = req.bus_data & write_keep[ctl_select];
          endcase
        end
      end
      CMD_TICK: begin
        if (!ctl_ready) begin
          if (ctl_regs[REG_COPY_MODE][7]) begin
            moved = ctl_vram[vram_index(ctl_block_ptr)];
            ctl_block_ptr++;
            n_vram_reads++;
          end else begin
            moved = ctl_fill;
          end
          ctl_vram[vram_index(ctl_update_ptr)] = moved;
          ctl_vram_written[vram_index(ctl_update_ptr)] = 1'b1;
          ctl_update_ptr++;
          ctl_words_left--;
          n_bytes_moved++;
          if (ctl_words_left == 8'h00) begin
            ctl_ready = 1'b1;
          end
        end
      end
      CMD_PEN: begin
        ctl_pen_addr = req.pen_position;
        ctl_pen_latched = 1'b1;
      end
      default: ;
    endcase
    reply.read_data = rd;
    reply.copy_ready = ctl_ready;
    return reply;
  endfunction

  // Requests that would read video RAM that was never written are turned into
  // status reads, so the stimulus never depends on undefined memory contents.
  task queue_request(input logic [2:0] op, input logic [7:0] val, input logic [15:0] pen);
    request_t r;
    r.req.cmd = op;
    r.req.bus_data = val;
    r.req.in_vblank = 1'($urandom_range(0, 1));
    r.req.pen_position = pen;
    if (op == CMD_REG_RD && ctl_select == REG_DATA &&
        !ctl_vram_written[vram_index(ctl_update_ptr)]) begin
      r.req.cmd = CMD_STATUS;
    end
    if (op == CMD_TICK && !ctl_ready && ctl_regs[REG_COPY_MODE][7] &&
        !ctl_vram_written[vram_index(ctl_block_ptr)]) begin
      r.req.cmd = CMD_STATUS;
    end
    r.pause = pause_next;
    pause_next = 1'b0;
    r.reply = controller_response(r.req);
    queued_requests.push_back(r);
    n_queued++;
  endtask

  task select_reg(input logic [5:0] idx);
    logic [7:0] sel;
    sel = 8'($urandom);
    sel[5:0] = idx;
    queue_request(CMD_SELECT, sel, 16'($urandom));
  endtask

  task write_reg(input logic [5:0] idx, input logic [7:0] val);
    select_reg(idx);
    queue_request(CMD_REG_WR, val, 16'($urandom));
  endtask

  task read_reg(input logic [5:0] idx);
    select_reg(idx);
    queue_request(CMD_REG_RD, 8'($urandom), 16'($urandom));
  endtask

  task set_pointer(input logic [5:0] hi_reg, input logic [5:0] lo_reg, input logic [15:0] val);
    write_reg(hi_reg, val[15:8]);
    write_reg(lo_reg, val[7:0]);
  endtask

  initial begin
    int         count;
    int         guard;
    int         n;
    bit         zero_count;
    bit         reloaded;
    logic [15:0] src;
    logic [15:0] dst;
    logic [5:0]  idx;

    ctl_select = '0;
    foreach (ctl_regs[k]) ctl_regs[k] = 8'h00;
    ctl_regs[REG_POLARITY] = POLARITY_RESET;
    ctl_update_ptr = '0;
    ctl_block_ptr = '0;
    ctl_words_left = '0;
    ctl_fill = '0;
    ctl_ready = 1'b1;
    ctl_pen_latched = 1'b0;
    ctl_pen_addr = '0;

    // Directed part: reset values, pen latch handling, masks, unmapped
    // registers, pointer wrap, idle ticks and the unused command codes.
    queue_request(CMD_STATUS, 8'h00, 16'h0000);
    queue_request(CMD_PEN, 8'h00, 16'hffff);
    queue_request(CMD_STATUS, 8'hff, 16'h0000);
    queue_request(CMD_SELECT, {2'b11, REG_PEN_HI}, 16'h0000);
    queue_request(CMD_REG_RD, 8'h00, 16'h0000);
    queue_request(CMD_REG_WR, 8'h00, 16'h0000);
    queue_request(CMD_SELECT, {2'b00, REG_PEN_LO}, 16'h0000);
    queue_request(CMD_REG_RD, 8'h00, 16'h0000);
    queue_request(CMD_PEN, 8'h00, 16'h0000);
    queue_request(CMD_SELECT, {2'b10, REG_POLARITY}, 16'hffff);
    queue_request(CMD_REG_RD, 8'h00, 16'h0000);
    queue_request(CMD_REG_WR, 8'h00, 16'h0000);
    queue_request(CMD_REG_RD, 8'h00, 16'h0000);
    queue_request(CMD_SELECT, 8'hff, 16'h0000);
    queue_request(CMD_REG_WR, 8'hff, 16'h0000);
    queue_request(CMD_REG_RD, 8'h00, 16'h0000);
    set_pointer(REG_UPD_HI, REG_UPD_LO, 16'hffff);
    write_reg(REG_DATA, 8'ha5);
    queue_request(CMD_TICK, 8'h00, 16'h0000);
    queue_request(CMD_UNUSED_6, 8'hff, 16'hffff);
    queue_request(CMD_UNUSED_7, 8'h00, 16'h0000);

    // A 256-byte fill from address zero gives the copies a valid source area.
    write_reg(REG_COPY_MODE, 8'h00);
    set_pointer(REG_UPD_HI, REG_UPD_LO, 16'h0000);
    write_reg(REG_DATA, 8'($urandom));
    write_reg(REG_WORDS, 8'h00);
    while (!ctl_ready) begin
      if ($urandom_range(0, 5) == 0) begin
        queue_request(CMD_STATUS, 8'($urandom), 16'($urandom));
      end else begin
        queue_request(CMD_TICK, 8'($urandom), 16'($urandom));
      end
    end

    while (n_queued < ITEM_TARGET) begin
      if (!pause_next && n_queued > PAUSE_AT && n_queued < PAUSE_AT + 40) begin
        pause_next = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          idx = 6'($urandom);
          write_reg(idx, 8'($urandom));
          queue_request(CMD_REG_RD, 8'($urandom), 16'($urandom));
          if ($urandom_range(0, 3) == 0) read_reg(REG_LAST - idx);
        end
        2, 3: begin
          dst = 16'($urandom);
          if ($urandom_range(0, 7) != 0) dst = 16'($urandom_range(0, 1023));
          n = $urandom_range(1, 8);
          set_pointer(REG_UPD_HI, REG_UPD_LO, dst);
          select_reg(REG_DATA);
          repeat (n) queue_request(CMD_REG_WR, 8'($urandom), 16'($urandom));
          set_pointer(REG_UPD_HI, REG_UPD_LO, dst);
          select_reg(REG_DATA);
          repeat (n) queue_request(CMD_REG_RD, 8'($urandom), 16'($urandom));
        end
        4, 5, 6: begin
          write_reg(REG_COPY_MODE, 8'($urandom));
          zero_count = ($urandom_range(0, 15) == 0);
          src = zero_count ? 16'h0000 : 16'($urandom_range(0, 200));
          dst = 16'($urandom);
          if ($urandom_range(0, 7) != 0) dst = 16'($urandom_range(0, 1023));
          set_pointer(REG_BLK_HI, REG_BLK_LO, src);
          set_pointer(REG_UPD_HI, REG_UPD_LO, dst);
          if ($urandom_range(0, 1) == 1) write_reg(REG_DATA, 8'($urandom));
          count = zero_count ? 0 : $urandom_range(1, 16);
          write_reg(REG_WORDS, 8'(count));
          reloaded = 1'b0;
          guard = 0;
          while (!ctl_ready && guard < 600) begin
            guard++;
            case ($urandom_range(0, 9))
              0: queue_request(CMD_STATUS, 8'($urandom), 16'($urandom));
              1: queue_request(CMD_REG_RD, 8'($urandom), 16'($urandom));
              2: begin
                if (!zero_count && !reloaded) begin
                  reloaded = 1'b1;
                  queue_request(CMD_REG_WR, 8'($urandom_range(1, 8)), 16'($urandom));
                end else begin
                  queue_request(CMD_TICK, 8'($urandom), 16'($urandom));
                end
              end
              default: queue_request(CMD_TICK, 8'($urandom), 16'($urandom));
            endcase
          end
          repeat ($urandom_range(0, 2)) queue_request(CMD_TICK, 8'($urandom), 16'($urandom));
          if ($urandom_range(0, 2) == 0) begin
            read_reg(REG_BLK_LO);
            read_reg(REG_UPD_HI);
          end
        end
        7: begin
          queue_request(CMD_PEN, 8'($urandom), 16'($urandom));
          queue_request(CMD_STATUS, 8'($urandom), 16'($urandom));
          read_reg($urandom_range(0, 1) ? REG_PEN_HI : REG_PEN_LO);
          queue_request(CMD_STATUS, 8'($urandom), 16'($urandom));
        end
        8: begin
          repeat ($urandom_range(1, 6)) begin
            queue_request(3'($urandom_range(0, 7)), 8'($urandom), 16'($urandom));
          end
        end
        default: begin
          case ($urandom_range(0, 4))
            0: read_reg(REG_UPD_HI);
            1: read_reg(REG_UPD_LO);
            2: read_reg(REG_BLK_HI);
            3: read_reg(REG_BLK_LO);
            default: read_reg(REG_WORDS);
          endcase
        end
      endcase
    end
    total_requests = n_queued;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_accepted < total_requests) @(posedge clk);
    while (pending_replies.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Summary: %0d transfers in, %0d results checked, %0d mismatches.",
             n_accepted, n_results, n_mismatch);
    $display("Summary: %0d bytes moved by block fill or copy, %0d video RAM reads.",
             n_bytes_moved, n_vram_reads);
    if (n_mismatch == 0) begin
      $display("[video_controller_register_copy_engine] OK");
    end else begin
      $display("[video_controller_register_copy_engine] ERROR");
    end
    $finish;
  end

  always @(negedge clk) begin : driver
    logic     nv;
    in_item_t nd;
    request_t head;
    nv = in_valid;
    nd = in_data;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_valid || in_hs) begin
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (queued_requests.size() > 0) begin
        head = queued_requests[0];
        if (!(head.pause && pending_replies.size() > 0)) begin
          head = queued_requests.pop_front();
          nv = 1'b1;
          nd = head.req;
          cur_reply = head.reply;
          if (!quiet_tail && hold_left == 0 && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 17);
          end
        end
      end
    end
    in_valid <= nv;
    in_data <= nd;
  end

  always @(negedge clk) begin : receiver
    logic nr;
    nr = 1'b1;
    if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      nr = 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      nr = 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
      recv_gap = $urandom_range(0, 16);
      nr = 1'b0;
    end
    out_ready <= nr;
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    in_hs = rst_n && in_valid && in_ready;
    if (in_hs) begin
      pending_replies.push_back(cur_reply);
      n_accepted++;
    end
    quiet_tail = (total_requests > 0) && (n_accepted + QUIET_TAIL >= total_requests);
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_replies.size() == 0) begin
        if (n_mismatch < 10) begin
          $display("Unexpected result transfer: read_data %02h copy_ready %0b",
                   out_data.read_data, out_data.copy_ready);
        end
        n_mismatch++;
      end else begin
        want = pending_replies.pop_front();
        if (out_data.read_data !== want.read_data ||
            out_data.copy_ready !== want.copy_ready) begin
          if (n_mismatch < 10) begin
            $display("Result %0d: expected read_data %02h copy_ready %0b, got %02h %0b",
                     n_results, want.read_data, want.copy_ready,
                     out_data.read_data, out_data.copy_ready);
          end
          n_mismatch++;
        end
      end
    end
    n_cycles++;
    if (n_cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               n_cycles, pending_replies.size());
      $display("[video_controller_register_copy_engine] ERROR");
      $finish;
    end
  end

endmodule
